// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the timer table RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ptts_pkg.sv =====
// Package for the periodic timer table scheduler.
// Holds field widths, operation codes, the table entry type, divider types and FSM states.
package ptts_pkg;

	localparam int DEFAULT_NUM_TIMERS = 16;

	localparam int OP_W    = 3;
	localparam int IDX_W   = 4;
	localparam int TIME_W  = 64;
	localparam int COUNT_W = 32;
	localparam int WAIT_W  = 32;

	localparam int IN_DATA_W    = 168;
	localparam int IN_USER_W    = 4;
	localparam int OUT_FIELDS_W = 103;
	localparam int OUT_DATA_W   = 104;

	typedef enum logic [OP_W-1:0] {
		OP_CREATE   = 3'd0,
		OP_UPDATE   = 3'd1,
		OP_DELETE   = 3'd2,
		OP_DISPATCH = 3'd3
	} op_t;

	localparam logic [WAIT_W-1:0] WAIT_NONE = 32'hffff_ffff;
	localparam logic [WAIT_W-1:0] WAIT_SAT  = 32'hffff_fffe;
	localparam logic [TIME_W-1:0] SAT_LIMIT = 64'd4294967295000;

	localparam int WAIT_DIVISOR = 1000;
	localparam int REM_W        = $clog2(WAIT_DIVISOR);
	localparam int DIV_RADIX_W  = 4;
	localparam int DIV_BITS     = 44;
	localparam int DIV_STEPS    = DIV_BITS / DIV_RADIX_W;
	localparam int STEP_W       = $clog2(DIV_STEPS);

	typedef struct packed {
		logic [TIME_W-1:0]  deadline;
		logic [TIME_W-1:0]  reload;
		logic [COUNT_W-1:0] fires;
	} timer_entry_t;

	typedef struct packed {
		logic                start;
		logic [DIV_BITS-1:0] dividend;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [WAIT_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PICK,
		S_READ,
		S_MODIFY,
		S_SCAN,
		S_DIFF,
		S_RANGE,
		S_DIV,
		S_OUT
	} state_t;

endpackage

// ===== hw/rtl/ptts_wait_div.sv =====
// Iterative divider by the constant wait unit, four quotient bits per cycle.
// Depends on ptts_pkg for widths and the request and response types.
module ptts_wait_div (
	input  logic               clk,
	input  logic               arst_n,
	input  ptts_pkg::div_req_t req,
	output ptts_pkg::div_rsp_t rsp
);

	localparam int REM_W   = ptts_pkg::REM_W;
	localparam int TRIAL_W = REM_W + 1;
	localparam int RADIX_W = ptts_pkg::DIV_RADIX_W;
	localparam int BITS    = ptts_pkg::DIV_BITS;
	localparam int STEP_W  = ptts_pkg::STEP_W;
	localparam logic [TRIAL_W-1:0] DIVISOR = TRIAL_W'(ptts_pkg::WAIT_DIVISOR);
	localparam logic [STEP_W-1:0]  LAST_STEP = STEP_W'(ptts_pkg::DIV_STEPS - 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [BITS-1:0]   work_q;
	logic [REM_W-1:0]  rem_q;
	logic [BITS-1:0]   work_n;
	logic [REM_W-1:0]  rem_n;

	always_comb begin
		logic [TRIAL_W-1:0] trial;
		logic [RADIX_W-1:0] qbits;
		rem_n = rem_q;
		qbits = '0;
		for (int k = 0; k < RADIX_W; k++) begin
			trial = {rem_n, work_q[BITS-1-k]};
			if (trial >= DIVISOR) begin
				rem_n = REM_W'(trial - DIVISOR);
				qbits[RADIX_W-1-k] = 1'b1;
			end else begin
				rem_n = trial[REM_W-1:0];
				qbits[RADIX_W-1-k] = 1'b0;
			end
		end
		work_n = {work_q[BITS-RADIX_W-1:0], qbits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= req.dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			work_q <= work_n;
			rem_q  <= rem_n;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = work_q[ptts_pkg::WAIT_W-1:0];

endmodule

// ===== hw/rtl/periodic_timer_table_scheduler_unit.sv =====
// Periodic timer table scheduler: top level with the timer memory and the control sequencer.
// Depends on ptts_pkg, ptts_wait_div and assert_macros.svh.
//
// One item is processed at a time. Create, update, delete and query run a read and a
// modify step of the target slot and then a scan of every slot; a dispatch first adds an expiry scan.
// When the earliest deadline lies ahead and in range, the wait division follows the scan.
// Every scan walks the single-read-port timer memory one slot per cycle, and the divider
// yields four quotient bits per cycle.
// A finished result sits in the output register, so the next item is taken while it waits.
`include "assert_macros.svh"

module periodic_timer_table_scheduler_unit #(
	parameter int NUM_TIMERS = ptts_pkg::DEFAULT_NUM_TIMERS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// timer_index[3:0], interval[67:4], repeat_count[99:68], now[163:100], zero fill
	input  logic [ptts_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// operation[2:0], absolute[3]
	input  logic [ptts_pkg::IN_USER_W-1:0]      s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// status[0], fired[1], fired_index[5:2], finished[6], deadline[70:7],
	// next_wait[102:71], zero fill
	output logic [ptts_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CW = $clog2(NUM_TIMERS + 1);
	localparam int TW = ptts_pkg::TIME_W;
	localparam logic [CW-1:0] SCAN_END = CW'(NUM_TIMERS);

	ptts_pkg::state_t state_q, state_d;

	logic [ptts_pkg::OP_W-1:0]    op_q;
	logic [ptts_pkg::IDX_W-1:0]   tmr_idx_q;
	logic [TW-1:0]                ival_q;
	logic [ptts_pkg::COUNT_W-1:0] rpt_q;
	logic                         abs_q;
	logic [TW-1:0]                now_q;

	ptts_pkg::timer_entry_t tmr_mem [NUM_TIMERS];
	ptts_pkg::timer_entry_t rd_data_s1;
	ptts_pkg::timer_entry_t mem_wdata;
	logic                   mem_re;
	logic                   mem_we;
	logic [IW-1:0]          mem_raddr;
	logic [IW-1:0]          tgt;

	logic [NUM_TIMERS-1:0] slot_deleted_q;
	logic [CW-1:0]         scan_cnt_q;
	logic                  rd_vld_s1;
	logic [IW-1:0]         rd_addr_s1;
	logic                  scan_issue;
	logic                  scan_done;

	logic          found_q;
	logic [IW-1:0] pick_q;
	logic [TW-1:0] best_q;
	logic          any_q;
	logic          status_q;
	logic          fired_q;
	logic          fin_q;
	logic [TW-1:0] dl_q;
	logic [TW-1:0] diff_q;
	logic          past_q;
	logic [ptts_pkg::WAIT_W-1:0] wait_q;

	logic                              m_valid_q;
	logic [ptts_pkg::OUT_DATA_W-1:0]   m_data_q;
	logic                              out_load;

	logic [IW-1:0] idx_slot;
	logic          idx_valid;
	logic          slot_live;
	logic [TW-1:0] d_eff;
	logic [TW-1:0] add_b;
	logic [TW-1:0] add_sum;
	logic [TW:0]   diff_full;
	logic          sat;
	logic          mod_status;
	logic          mod_fin;
	logic          del_set;
	logic          del_clr;
	logic          is_disp;

	ptts_pkg::div_req_t div_req;
	ptts_pkg::div_rsp_t div_rsp;

	ptts_wait_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign s_axis_tready = (state_q == ptts_pkg::S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	assign is_disp   = (op_q == ptts_pkg::OP_DISPATCH);
	assign idx_slot  = IW'(tmr_idx_q);
	assign idx_valid = (9'(tmr_idx_q) < 9'(NUM_TIMERS));
	assign slot_live = idx_valid && !slot_deleted_q[idx_slot];
	assign tgt       = is_disp ? pick_q : idx_slot;
	assign d_eff     = slot_deleted_q[rd_addr_s1] ? '0 : rd_data_s1.deadline;
	assign scan_done = (scan_cnt_q == SCAN_END) && rd_vld_s1;
	assign diff_full = {1'b0, best_q} - {1'b0, now_q};
	assign sat       = (diff_q >= ptts_pkg::SAT_LIMIT);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptts_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		scan_issue       = 1'b0;
		mem_re           = 1'b0;
		mem_raddr        = scan_cnt_q[IW-1:0];
		div_req.start    = 1'b0;
		div_req.dividend = diff_q[ptts_pkg::DIV_BITS-1:0];
		out_load         = 1'b0;
		unique case (state_q)
			ptts_pkg::S_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = (s_axis_tuser[2:0] == ptts_pkg::OP_DISPATCH) ?
						ptts_pkg::S_PICK : ptts_pkg::S_READ;
				end
			end
			ptts_pkg::S_PICK: begin
				scan_issue = (scan_cnt_q != SCAN_END);
				mem_re     = scan_issue;
				if (scan_done) begin
					state_d = ptts_pkg::S_READ;
				end
			end
			ptts_pkg::S_READ: begin
				mem_re    = 1'b1;
				mem_raddr = tgt;
				state_d   = ptts_pkg::S_MODIFY;
			end
			ptts_pkg::S_MODIFY: begin
				state_d = ptts_pkg::S_SCAN;
			end
			ptts_pkg::S_SCAN: begin
				scan_issue = (scan_cnt_q != SCAN_END);
				mem_re     = scan_issue;
				if (scan_done) begin
					state_d = ptts_pkg::S_DIFF;
				end
			end
			ptts_pkg::S_DIFF: begin
				state_d = ptts_pkg::S_RANGE;
			end
			ptts_pkg::S_RANGE: begin
				if (any_q && !past_q && !sat) begin
					div_req.start = 1'b1;
					state_d       = ptts_pkg::S_DIV;
				end else begin
					state_d = ptts_pkg::S_OUT;
				end
			end
			ptts_pkg::S_DIV: begin
				if (div_rsp.done) begin
					state_d = ptts_pkg::S_OUT;
				end
			end
			ptts_pkg::S_OUT: begin
				if (!m_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ptts_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ptts_pkg::S_IDLE;
			end
		endcase
	end

	// Read-modify-write of the target slot
	always_comb begin
		add_b      = is_disp ? rd_data_s1.reload : ival_q;
		add_sum    = now_q + add_b;
		mod_fin    = (rd_data_s1.fires <= 32'd1);
		mem_we     = 1'b0;
		del_set    = 1'b0;
		del_clr    = 1'b0;
		mod_status = 1'b0;
		if (abs_q) begin
			mem_wdata = '{deadline: ival_q, reload: rd_data_s1.reload, fires: '0};
		end else begin
			mem_wdata = '{deadline: add_sum, reload: ival_q, fires: rpt_q};
		end
		if (state_q == ptts_pkg::S_MODIFY) begin
			unique case (op_q)
				ptts_pkg::OP_CREATE: begin
					mod_status = !idx_valid;
					if (idx_valid) begin
						mem_we  = 1'b1;
						del_clr = 1'b1;
						if (abs_q) begin
							mem_wdata.reload = '0;
						end
					end
				end
				ptts_pkg::OP_UPDATE: begin
					mod_status = !slot_live;
					mem_we     = slot_live;
				end
				ptts_pkg::OP_DELETE: begin
					mod_status = !slot_live;
					del_set    = slot_live;
				end
				ptts_pkg::OP_DISPATCH: begin
					mem_we = found_q;
					if (mod_fin) begin
						mem_wdata = '{deadline: '0, reload: rd_data_s1.reload, fires: '0};
					end else begin
						mem_wdata = '{deadline: add_sum, reload: rd_data_s1.reload,
							fires: rd_data_s1.fires - 1'b1};
					end
				end
				default: begin
					mod_status = !slot_live;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tmr_mem[tgt] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_s1 <= tmr_mem[mem_raddr];
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_deleted_q <= '1;
			scan_cnt_q     <= '0;
			rd_vld_s1      <= 1'b0;
			found_q        <= 1'b0;
			any_q          <= 1'b0;
			status_q       <= 1'b0;
			fired_q        <= 1'b0;
			fin_q          <= 1'b0;
			m_valid_q      <= 1'b0;
		end else begin
			rd_vld_s1 <= scan_issue;
			if (scan_issue) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end else if (state_q != ptts_pkg::S_PICK && state_q != ptts_pkg::S_SCAN) begin
				scan_cnt_q <= '0;
			end
			if (del_set) begin
				slot_deleted_q[idx_slot] <= 1'b1;
			end else if (del_clr) begin
				slot_deleted_q[idx_slot] <= 1'b0;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				found_q <= 1'b0;
			end else if (state_q == ptts_pkg::S_PICK && rd_vld_s1 && d_eff != '0 &&
				d_eff <= now_q && (!found_q || d_eff > best_q)) begin
				found_q <= 1'b1;
			end
			if (state_q == ptts_pkg::S_MODIFY) begin
				any_q    <= 1'b0;
				status_q <= mod_status;
				fired_q  <= is_disp && found_q;
				fin_q    <= is_disp && found_q && mod_fin;
			end else if (state_q == ptts_pkg::S_SCAN && rd_vld_s1 && d_eff != '0) begin
				any_q <= 1'b1;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_q      <= s_axis_tuser[2:0];
			abs_q     <= s_axis_tuser[3];
			tmr_idx_q <= s_axis_tdata[3:0];
			ival_q    <= s_axis_tdata[67:4];
			rpt_q     <= s_axis_tdata[99:68];
			now_q     <= s_axis_tdata[163:100];
		end
		rd_addr_s1 <= mem_raddr;
		if (state_q == ptts_pkg::S_PICK && rd_vld_s1 && d_eff != '0 && d_eff <= now_q &&
			(!found_q || d_eff > best_q)) begin
			best_q <= d_eff;
			pick_q <= rd_addr_s1;
		end
		if (state_q == ptts_pkg::S_SCAN && rd_vld_s1 && d_eff != '0 &&
			(!any_q || d_eff < best_q)) begin
			best_q <= d_eff;
		end
		if (state_q == ptts_pkg::S_MODIFY) begin
			dl_q <= (is_disp && found_q) ? mem_wdata.deadline : '0;
		end else if (state_q == ptts_pkg::S_SCAN && rd_vld_s1 && !fired_q && idx_valid &&
			rd_addr_s1 == idx_slot) begin
			dl_q <= d_eff;
		end
		if (state_q == ptts_pkg::S_DIFF) begin
			diff_q <= diff_full[TW-1:0];
			past_q <= diff_full[TW];
		end
		if (state_q == ptts_pkg::S_RANGE) begin
			if (!any_q) begin
				wait_q <= ptts_pkg::WAIT_NONE;
			end else if (past_q) begin
				wait_q <= '0;
			end else begin
				wait_q <= ptts_pkg::WAIT_SAT;
			end
		end else if (state_q == ptts_pkg::S_DIV && div_rsp.done) begin
			wait_q <= div_rsp.quotient;
		end
		if (out_load) begin
			m_data_q <= {
				{(ptts_pkg::OUT_DATA_W - ptts_pkg::OUT_FIELDS_W){1'b0}},
				wait_q,
				dl_q,
				fin_q,
				(fired_q ? ptts_pkg::IDX_W'(pick_q) : {ptts_pkg::IDX_W{1'b0}}),
				fired_q,
				status_q
			};
		end
	end

	`ASSERT_IMPLIES(a_write_live_slot, mem_we && op_q != ptts_pkg::OP_CREATE, !slot_deleted_q[tgt], "write to a deleted slot")
	`ASSERT_IMPLIES(a_finish_needs_fire, fin_q, fired_q, "finished without a firing")
	`ASSERT_IMPLIES(a_div_done_in_div, div_rsp.done, state_q == ptts_pkg::S_DIV, "divider done outside wait")
	`ASSERT_NEXT(a_accept_leaves_idle, s_axis_tvalid && s_axis_tready, state_q != ptts_pkg::S_IDLE, "item accepted but sequencer idle")

endmodule
